[design/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// bffa_pkg
// shared types and constants of the first-fit bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

    // request kinds carried on s_tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // bitmap bytes held in one ram word
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    typedef logic [LANES-1:0][7:0] word_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // outcome of looking for a clear bit in one ram word
    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] lane;
        logic [2:0]        bit_pos;
        logic [7:0]        upd_byte;
    } scan_hit_t;

endpackage : bffa_pkg

`default_nettype wire

[design/bffa_word_scan.sv]
// ----------------------------------------------------------------------------
// bffa_word_scan
// finds the first clear bit in one bitmap word, lowest byte first, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_word_scan
    import bffa_pkg::*;
(
    input  var word_t            word_i,
    input  var logic [LANES-1:0] lane_ok_i,   // lanes that lie inside the bitmap
    output scan_hit_t            result_o
);

    logic [7:0] bit_found;
    logic [2:0] bit_first [LANES];

    // first clear bit of every byte, counted from the msb
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            bit_found[i] = 1'b0;
            bit_first[i] = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (!word_i[i][7-b]) begin
                    bit_found[i] = 1'b1;
                    bit_first[i] = 3'(b);
                end
            end
        end
    end

    // lowest lane with a clear bit wins
    always_comb begin
        result_o = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (lane_ok_i[i] && bit_found[i]) begin
                result_o.hit      = 1'b1;
                result_o.lane     = LANE_W'(i);
                result_o.bit_pos  = bit_first[i];
                result_o.upd_byte = word_i[i] | (8'h80 >> bit_first[i]);
            end
        end
    end

endmodule : bffa_word_scan

`default_nettype wire

[design/bitmap_first_free_allocator_core.sv]
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_core
// first-fit block allocator over a byte bitmap held in on-chip ram
// ----------------------------------------------------------------------------
// load word: the byte is written in the accept cycle; the result then passes ST_FINISH
// allocate word: one 64-bit ram word (8 bitmap bytes) is checked per cycle,
//   from word 0 upward, until the first clear bit or the last word; a full bitmap
//   gives a not-found result
// one item in flight; next word accepted once the previous result is registered
// aresetn (sync, active low) clears control only; bitmap bytes are undefined
//   until loaded, there is no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator_core
    import bffa_pkg::*;
#(
    parameter int BITMAP_BYTES = 8192
) (
    input  var logic        aclk,
    input  var logic        aresetn,

    // request stream
    input  var logic        s_tvalid,
    output logic            s_tready,
    input  var logic [23:0] s_tdata,    // [12:0] load_index, [20:13] load_value, rest zero
    input  var logic        s_tuser,    // [0] req_type

    // result stream
    output logic            m_tvalid,
    input  var logic        m_tready,
    output logic [39:0]     m_tdata,    // [15:0] block_index, [28:16] byte_index,
                                        // [31:29] bit_position, [39:32] updated_byte
    output logic            m_tuser     // [0] found
);

    // ram geometry: 8 bitmap bytes per word
    localparam int WORDS = (BITMAP_BYTES + LANES - 1) / LANES;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = AW + 1;

    // ------------------------------------------------------------------
    // input word unpack
    // ------------------------------------------------------------------
    logic        in_req;
    logic [12:0] in_index;
    logic [7:0]  in_value;
    logic        in_fire;

    assign in_req   = s_tuser;
    assign in_index = s_tdata[12:0];
    assign in_value = s_tdata[20:13];
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [CW-1:0]   issue_reg, issue_next;   // next word address to read
    logic            rvalid_reg;              // ram data of raddr_reg is present
    logic [AW-1:0]   raddr_reg;               // word address behind rd_data_reg

    // pending result, held until the output register frees up
    logic            res_found_reg,  res_found_next;
    logic [15:0]     res_block_reg,  res_block_next;
    logic [12:0]     res_byte_reg,   res_byte_next;
    logic [2:0]      res_bit_reg,    res_bit_next;
    logic [7:0]      res_upd_reg,    res_upd_next;

    // output register
    logic            m_valid_reg;
    logic            m_found_reg;
    logic [15:0]     m_block_reg;
    logic [12:0]     m_byte_reg;
    logic [2:0]      m_bit_reg;
    logic [7:0]      m_upd_reg;

    // ------------------------------------------------------------------
    // bitmap ram: byte-lane write enables, one registered read port
    // ------------------------------------------------------------------
    word_t           bitmap_mem [WORDS];
    word_t           rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [LANES-1:0] wr_be;
    logic [7:0]      wr_byte;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (wr_en && wr_be[i]) begin
                bitmap_mem[wr_addr][i] <= wr_byte;
            end
        end
        if (rd_en) begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // word check: lanes past the end of the bitmap count as full
    // ------------------------------------------------------------------
    logic [LANES-1:0] lane_ok;
    scan_hit_t        scan;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_ok[i] = 32'({raddr_reg, LANE_W'(i)}) < 32'(BITMAP_BYTES);
        end
    end

    bffa_word_scan u_word_scan (
        .word_i    (rd_data_reg),
        .lane_ok_i (lane_ok),
        .result_o  (scan)
    );

    // scan outcome of the current cycle
    logic scan_hit;
    logic scan_miss;       // last word checked, nothing clear
    logic scan_done;
    logic [31:0] hit_byte;

    assign scan_hit  = (state_reg == ST_SCAN) && rvalid_reg && scan.hit;
    assign scan_miss = (state_reg == ST_SCAN) && rvalid_reg && !scan.hit
                       && (32'(raddr_reg) == 32'(WORDS - 1));
    assign scan_done = scan_hit || scan_miss;
    assign hit_byte  = 32'({raddr_reg, scan.lane});

    // load target
    logic            load_in_range;
    logic [AW-1:0]   load_word;
    logic [LANE_W-1:0] load_lane;

    assign load_in_range = 32'(in_index) < 32'(BITMAP_BYTES);
    assign load_word     = AW'(32'(in_index) >> LANE_W);
    assign load_lane     = in_index[LANE_W-1:0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (in_req == REQ_ALLOC) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and ram controls
    // ------------------------------------------------------------------
    always_comb begin
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[AW-1:0];
        issue_next     = issue_reg;
        wr_en          = 1'b0;
        wr_addr        = load_word;
        wr_be          = '0;
        wr_byte        = in_value;
        res_found_next = res_found_reg;
        res_block_next = res_block_reg;
        res_byte_next  = res_byte_reg;
        res_bit_next   = res_bit_reg;
        res_upd_next   = res_upd_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                issue_next = '0;
                if (in_fire) begin
                    // loads and misses both report an all-zero result
                    res_found_next = 1'b0;
                    res_block_next = '0;
                    res_byte_next  = '0;
                    res_bit_next   = '0;
                    res_upd_next   = '0;
                    if (in_req == REQ_LOAD) begin
                        wr_en            = load_in_range;
                        wr_be[load_lane] = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // keep one read in flight while the previous word is checked
                rd_en = (32'(issue_reg) < 32'(WORDS)) && !scan_done;
                if (rd_en) begin
                    issue_next = issue_reg + CW'(1);
                end
                if (scan_hit) begin
                    // mark the block used
                    wr_en             = 1'b1;
                    wr_addr           = raddr_reg;
                    wr_be[scan.lane]  = 1'b1;
                    wr_byte           = scan.upd_byte;
                    res_found_next    = 1'b1;
                    res_block_next    = 16'({hit_byte, scan.bit_pos});
                    res_byte_next     = 13'(hit_byte);
                    res_bit_next      = scan.bit_pos;
                    res_upd_next      = scan.upd_byte;
                end
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issue_reg  <= issue_next;
            rvalid_reg <= rd_en;
            if (state_reg == ST_FINISH && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            raddr_reg <= rd_addr;
        end
        res_found_reg <= res_found_next;
        res_block_reg <= res_block_next;
        res_byte_reg  <= res_byte_next;
        res_bit_reg   <= res_bit_next;
        res_upd_reg   <= res_upd_next;
        if (state_reg == ST_FINISH && (!m_valid_reg || m_tready)) begin
            m_found_reg <= res_found_reg;
            m_block_reg <= res_block_reg;
            m_byte_reg  <= res_byte_reg;
            m_bit_reg   <= res_bit_reg;
            m_upd_reg   <= res_upd_reg;
        end
    end

    // ------------------------------------------------------------------
    // output word pack
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {m_upd_reg, m_bit_reg, m_byte_reg, m_block_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a found block always has its bit set in the reported byte
    a_found_bit_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> ((m_upd_reg & (8'h80 >> m_bit_reg)) != 8'h00))
        else $error("reported byte lacks the allocated bit");

    // loads and full-bitmap results carry an all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_tdata == '0))
        else $error("non-allocation result has nonzero payload");

    // returned ram data is only pending during a scan
    a_rvalid_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> (state_reg == ST_SCAN))
        else $error("ram read data outside of a scan");

    // block number and byte/bit fields agree
    a_block_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (m_block_reg == {m_byte_reg, m_bit_reg}))
        else $error("block index disagrees with byte and bit");

    // one item at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("second word accepted while busy");

endmodule : bitmap_first_free_allocator_core

`default_nettype wire
